>>> hdl/tss_pkg.sv
package tss_pkg;

  localparam int unsigned TaskSlots    = 64;
  localparam logic [31:0] ProgramMagic = 32'hE59D0000;
  localparam logic [7:0]  ResetSlice   = 8'd5;

  typedef enum logic [1:0] {
    ST_FREE  = 2'd0,
    ST_READY = 2'd1,
    ST_SLEEP = 2'd2
  } task_st_e;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_CREATE = 2'd1,
    MODE_KILL   = 2'd2,
    MODE_SLEEP  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_BAD_PRG = 2'd1,
    STAT_FULL    = 2'd2
  } status_e;

  localparam logic CFG_NEW_SLICE = 1'b0;
  localparam logic CFG_KERN_PRIO = 1'b1;

  // one table entry: status, slice, priority, timer
  typedef struct packed {
    logic [1:0]  st;
    logic [7:0]  slice;
    logic [7:0]  prio;
    logic [15:0] timer;
  } entry_t;

  // memory port request from the sequencer
  typedef struct packed {
    logic   wr_en;
    entry_t wr_data;
  } mem_req_t;

endpackage

>>> hdl/tss_table.sv
module tss_table
  import tss_pkg::*;
#(
  parameter int unsigned TASK_SLOTS = TaskSlots,
  localparam int unsigned IdxW = $clog2(TASK_SLOTS)
) (
  input  logic            clk_i,
  input  logic [IdxW-1:0] rd_addr_i,
  output entry_t          rd_data_o,
  input  logic [IdxW-1:0] wr_addr_i,
  input  mem_req_t        wr_req_i
);

  entry_t mem_q [TASK_SLOTS];

  always_ff @(posedge clk_i) begin
    if (wr_req_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_req_i.wr_data;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

>>> hdl/task_slice_scheduler_core.sv
// Channel   Dir  Handshake                Payload
// s_axis    in   s_axis_tvalid/tready     mode,user,prio,first_word,kill_id,sleep_ticks
// m_axis    out  m_axis_tvalid/tready     current,switched,previous,created,status
// cfg       in   cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
// An item takes up to four sweeps of the task table through its one read port
// and one write port, plus single-entry read-modify-write updates, before the
// result is loaded. After reset one clearing sweep runs before the first item
// or register write is taken; register writes are taken only while idle. The
// result sits in an output register; a stalled output holds the next item off.
module task_slice_scheduler_core
  import tss_pkg::*;
#(
  parameter int unsigned TASK_SLOTS = TaskSlots,
  localparam int unsigned IdxW = $clog2(TASK_SLOTS)
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] mode, [2] in_user_space, [10:3] task_priority, [42:11] first_word,
  // [48:43] kill_id, [64:49] sleep_ticks, zero fill to 72
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [5:0] current_task, [6] switched, [12:7] previous_task,
  // [18:13] created_id, [20:19] status, zero fill to 24
  output logic [23:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_WAKE   = 10'b0000000100, // tick: count down sleepers, then touch running slice
    S_FIND   = 10'b0000001000, // create/kill search sweep
    S_PICK1  = 10'b0000010000,
    S_REFILL = 10'b0000100000,
    S_PICK2  = 10'b0001000000,
    S_ONE    = 10'b0010000000, // single entry read-modify-write
    S_DONE   = 10'b0100000000,
    S_OUT    = 10'b1000000000
  } state_e;

  localparam int unsigned CntW = IdxW + 1;
  localparam logic [CntW-1:0] LastCnt = CntW'(TASK_SLOTS + 1);

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;       // read address counter, data index is one behind
  logic [IdxW-1:0] raddr;
  entry_t          rdata;
  mem_req_t        wreq;
  logic [IdxW-1:0] waddr;

  logic [7:0]  new_slice_q;
  logic [IdxW-1:0] run_q, run_d, prev_q;
  logic [6:0]  ready_q, ready_d;
  logic [1:0]  mode_q;
  logic        user_q;
  logic [7:0]  tprio_q;
  logic        magic_ok_q;
  logic [5:0]  kid_q;
  logic [15:0] ticks_q;
  logic [IdxW-1:0] pick_q, pick_d;
  logic [8:0]  best_q, best_d;        // bit 8 set means none yet
  logic        found_q, found_d;
  logic [IdxW-1:0] created_q, created_d;
  logic [1:0]  stat_q, stat_d;
  logic [1:0]  one_op_q, one_op_d;    // 0 tick slice, 1 sleep entry, 2 reload k0
  logic [23:0] out_q, out_d;
  logic        ovalid_q, ovalid_d;

  localparam logic [1:0] OP_TICK = 2'd0, OP_SLEEP = 2'd1, OP_RELOAD = 2'd2;

  logic [IdxW-1:0] didx;
  logic            dval, in_fire, cfg_fire;
  entry_t          e;

  assign raddr       = cnt_q[IdxW-1:0];
  assign didx        = IdxW'(cnt_q - CntW'(1));
  assign dval        = (cnt_q != '0) && (cnt_q <= CntW'(TASK_SLOTS));
  // a pending register write goes first
  assign s_axis_tready = (state_q == S_IDLE) && !ovalid_q && !cfg_valid_i;
  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_fire     = s_axis_tvalid && s_axis_tready;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = out_q;

  tss_table #(.TASK_SLOTS(TASK_SLOTS)) u_table (
    .clk_i     (clk_i),
    .rd_addr_i (raddr),
    .rd_data_o (rdata),
    .wr_addr_i (waddr),
    .wr_req_i  (wreq)
  );

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; run_d = run_q; ready_d = ready_q;
    pick_d = pick_q; best_d = best_q; found_d = found_q; created_d = created_q;
    stat_d = stat_q; one_op_d = one_op_q;
    out_d = out_q; ovalid_d = ovalid_q;
    wreq = '0; waddr = didx; e = rdata;
    if (ovalid_q && m_axis_tready) ovalid_d = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        waddr = raddr;
        wreq.wr_en = 1'b1;
        wreq.wr_data = (raddr == '0) ? entry_t'{ST_READY, ResetSlice, ResetSlice, 16'd0}
                                     : entry_t'('0);
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(TASK_SLOTS - 1)) begin
          cnt_d = '0; state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cfg_fire && cfg_index_i == CFG_KERN_PRIO) begin
          waddr = '0; wreq.wr_en = 1'b1;
          wreq.wr_data = '{ST_READY, cfg_data_i, cfg_data_i, 16'd0};
        end else if (in_fire) begin
          cnt_d = '0; found_d = 1'b0; created_d = '0; stat_d = STAT_OK;
          unique case (mode_e'(s_axis_tdata[1:0]))
            MODE_TICK: state_d = S_WAKE;
            MODE_CREATE: begin
              if (s_axis_tdata[42:11] != ProgramMagic) begin
                stat_d = STAT_BAD_PRG; state_d = S_DONE;
              end else state_d = S_FIND;
            end
            MODE_KILL: state_d = S_FIND;
            MODE_SLEEP: begin
              cnt_d = CntW'(run_q); one_op_d = OP_SLEEP; state_d = S_ONE;
            end
          endcase
        end
      end
      S_WAKE: begin
        cnt_d = cnt_q + 1'b1;
        if (dval && didx != '0 && rdata.st == ST_SLEEP) begin
          e.timer = rdata.timer - 16'd1;
          if (e.timer == '0) begin
            e.st = ST_READY; ready_d = ready_d + 7'd1;
          end
          wreq.wr_en = 1'b1; wreq.wr_data = e;
        end
        if (cnt_q == LastCnt - 1'b1) begin
          cnt_d = CntW'(run_q); one_op_d = OP_TICK; state_d = S_ONE;
        end
      end
      S_ONE: begin
        // cnt_q holds addr; wait for the registered read data using bit trick:
        // cnt upper bit used as phase flag
        if (!cnt_q[IdxW]) begin
          cnt_d = {1'b1, cnt_q[IdxW-1:0]};
        end else begin
          waddr = cnt_q[IdxW-1:0];
          cnt_d = '0;
          best_d = 9'h100; pick_d = '0;
          unique case (one_op_q)
            OP_TICK: begin
              if (rdata.slice != 8'd0) e.slice = rdata.slice - 8'd1;
              wreq.wr_en = 1'b1; wreq.wr_data = e;
              state_d = ((rdata.st != ST_READY || e.slice == 8'd0) && user_q)
                        ? S_PICK1 : S_DONE;
            end
            OP_SLEEP: begin
              if (run_q != '0 && rdata.st == ST_READY) begin
                e.st = ST_SLEEP;
                e.timer = (ticks_q == 16'd0) ? 16'd1 : ticks_q;
                wreq.wr_en = 1'b1; wreq.wr_data = e;
                ready_d = ready_q - 7'd1;
                state_d = S_PICK1;
              end else state_d = S_DONE;
            end
            default: begin
              e.slice = rdata.prio;
              wreq.wr_en = 1'b1; wreq.wr_data = e;
              state_d = S_DONE;
            end
          endcase
          if (state_d == S_PICK1 && ready_d == 7'd1 && run_q == '0) begin
            // lone kernel task: reload slot 0 slice instead
            one_op_d = OP_RELOAD; cnt_d = '0; state_d = S_ONE;
          end
        end
      end
      S_FIND: begin
        cnt_d = cnt_q + 1'b1;
        if (dval && !found_q) begin
          if (mode_q == MODE_CREATE) begin
            if (rdata.st == ST_FREE) begin
              found_d = 1'b1; created_d = didx;
              wreq.wr_en = 1'b1;
              wreq.wr_data = '{ST_READY, new_slice_q, tprio_q, 16'd0};
              ready_d = ready_q + 7'd1;
            end
          end else if (didx != '0 && rdata.st != ST_FREE &&
                       (kid_q == 6'd0 || 32'(kid_q) == 32'(didx))) begin
            found_d = 1'b1;
            if (rdata.st == ST_READY) ready_d = ready_q - 7'd1;
            wreq.wr_en = 1'b1; wreq.wr_data = '0;
          end
        end
        if (cnt_q == LastCnt - 1'b1) begin
          cnt_d = '0; best_d = 9'h100; pick_d = '0;
          if (mode_q == MODE_CREATE) begin
            if (!found_d) stat_d = STAT_FULL;
            state_d = S_DONE;
          end else if (ready_d == 7'd1 && run_q == '0) begin
            one_op_d = OP_RELOAD; state_d = S_ONE;
          end else state_d = S_PICK1;
        end
      end
      S_PICK1, S_PICK2: begin
        cnt_d = cnt_q + 1'b1;
        if (dval && didx != '0 && rdata.st == ST_READY &&
            (best_q[8] || {1'b0, rdata.slice} > best_q)) begin
          best_d = {1'b0, rdata.slice}; pick_d = didx;
        end
        if (cnt_q == LastCnt - 1'b1) begin
          cnt_d = '0;
          if (state_q == S_PICK2) begin
            run_d = (best_d[8] || best_d == 9'd0) ? '0 : pick_d;
            state_d = S_DONE;
          end else if (best_d != 9'd0) begin
            run_d = pick_d; state_d = S_DONE;
          end else state_d = S_REFILL;
          best_d = 9'h100; pick_d = '0;
        end
      end
      S_REFILL: begin
        cnt_d = cnt_q + 1'b1;
        if (dval && didx != '0 && rdata.st == ST_READY) begin
          e.slice = rdata.prio; wreq.wr_en = 1'b1; wreq.wr_data = e;
        end
        if (cnt_q == LastCnt - 1'b1) begin
          cnt_d = '0; state_d = S_PICK2;
        end
      end
      S_DONE: begin
        out_d = {3'd0, stat_q, 6'(created_q), 6'(prev_q), run_q != prev_q, 6'(run_q)};
        ovalid_d = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; cnt_q <= '0; run_q <= '0; ready_q <= '0;
      new_slice_q <= ResetSlice; ovalid_q <= 1'b0;
      found_q <= 1'b0; stat_q <= STAT_OK; one_op_q <= OP_TICK;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; run_q <= run_d; ready_q <= ready_d;
      ovalid_q <= ovalid_d; found_q <= found_d; stat_q <= stat_d;
      one_op_q <= one_op_d;
      if (cfg_fire && cfg_index_i == CFG_NEW_SLICE) new_slice_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pick_q <= pick_d; best_q <= best_d; created_q <= created_d; out_q <= out_d;
    if (in_fire) begin
      mode_q <= s_axis_tdata[1:0]; user_q <= s_axis_tdata[2];
      tprio_q <= s_axis_tdata[10:3]; magic_ok_q <= s_axis_tdata[42:11] == ProgramMagic;
      kid_q <= s_axis_tdata[48:43]; ticks_q <= s_axis_tdata[64:49];
      prev_q <= run_q;
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid) else $error("accept while result pending");
  a_create_magic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIND && mode_q == MODE_CREATE) |-> magic_ok_q)
    else $error("create search with bad word");
  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed under stall");
`endif

endmodule
